// ===== sv/time_ordered_event_queue_defines.svh =====
// Assertion macros used by the event queue top level.
`ifndef TIME_ORDERED_EVENT_QUEUE_DEFINES_SVH
`define TIME_ORDERED_EVENT_QUEUE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TOEQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define TOEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/toeq_pkg.sv =====
// Types, commands and default sizes of the time-ordered event queue.
`default_nettype none

package toeq_pkg;

	localparam int DEF_CAPACITY     = 16;
	localparam int DEF_TIME_BITS    = 32;
	localparam int DEF_PAYLOAD_BITS = 32;

	localparam int CMD_BITS = 2;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// Per-cycle control broadcast to every cell of the chain.
	typedef struct packed {
		logic push_en;
		logic pop_en;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/toeq_cell.sv =====
// One slot of the sorted chain: holds an event and shifts it left or right.
`default_nettype none

module toeq_cell import toeq_pkg::*; #(
	parameter int TIME_BITS    = DEF_TIME_BITS,
	parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
	input  wire logic                    clk,
	input  wire cell_ctrl_t              ctrl,
	input  wire logic                    occupied,
	input  wire logic [TIME_BITS-1:0]    new_time,
	input  wire logic [PAYLOAD_BITS-1:0] new_payload,
	input  wire logic                    left_le,
	input  wire logic [TIME_BITS-1:0]    left_time,
	input  wire logic [PAYLOAD_BITS-1:0] left_payload,
	input  wire logic [TIME_BITS-1:0]    right_time,
	input  wire logic [PAYLOAD_BITS-1:0] right_payload,
	output logic                         le,
	output logic [TIME_BITS-1:0]         slot_time,
	output logic [PAYLOAD_BITS-1:0]      slot_payload
);

	logic [TIME_BITS-1:0]    time_q;
	logic [PAYLOAD_BITS-1:0] payload_q;

	// Keep this slot ahead of a new event with the same or a later time
	assign le = occupied && (time_q <= new_time);

	// Insert: keep, take the new event, or take the left neighbor; pop: take the right
	always_ff @(posedge clk) begin
		if (ctrl.push_en && !le) begin
			if (left_le) begin
				time_q    <= new_time;
				payload_q <= new_payload;
			end else begin
				time_q    <= left_time;
				payload_q <= left_payload;
			end
		end else if (ctrl.pop_en) begin
			time_q    <= right_time;
			payload_q <= right_payload;
		end
	end

	assign slot_time    = time_q;
	assign slot_payload = payload_q;

endmodule

`default_nettype wire

// ===== sv/time_ordered_event_queue.sv =====
// Top level of the time-ordered event queue: cell chain, fill count, result register.
//
//  channel  dir  fields
//  s_*      in   tuser: cmd | tdata: event_time, event_payload
//  m_*      out  tuser: pop_ok, push_dropped, head_valid
//                tdata: popped_time, popped_payload, head_time, head_payload, entry_count
//
// All cells compare against the new time in parallel and shift on the same edge,
// so one transfer per cycle is sustained while the results are taken.
// The result is registered in the cycle after the input transfer and is held until taken.
// A stalled result blocks new input unless it is taken in that same cycle.
// Reset clears the fill count and the result valid; slot contents are not reset.
`default_nettype none

module time_ordered_event_queue import toeq_pkg::*; #(
	parameter int CAPACITY     = DEF_CAPACITY,
	parameter int TIME_BITS    = DEF_TIME_BITS,
	parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
	localparam int CNT_BITS    = $clog2(CAPACITY + 1),
	localparam int IN_RAW      = TIME_BITS + PAYLOAD_BITS,
	localparam int IN_W        = ((IN_RAW + 7) / 8) * 8,
	localparam int OUT_RAW     = 2 * TIME_BITS + 2 * PAYLOAD_BITS + CNT_BITS,
	localparam int OUT_W       = ((OUT_RAW + 7) / 8) * 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [IN_W-1:0]     s_tdata,  // event_time, event_payload
	input  wire logic [CMD_BITS-1:0] s_tuser,  // cmd
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OUT_W-1:0]         m_tdata,  // popped_time, popped_payload, head_time,
	                                           // head_payload, entry_count
	output logic [2:0]               m_tuser   // pop_ok, push_dropped, head_valid
);

	`include "time_ordered_event_queue_defines.svh"

	logic                    in_xfer;
	cmd_t                    cmd;
	logic [TIME_BITS-1:0]    in_time;
	logic [PAYLOAD_BITS-1:0] in_payload;
	logic                    full;
	logic                    empty;
	cell_ctrl_t              ctrl;
	logic                    clear_en;
	logic [CNT_BITS-1:0]     count_q;

	logic [TIME_BITS-1:0]    slot_time    [CAPACITY];
	logic [PAYLOAD_BITS-1:0] slot_payload [CAPACITY];
	logic                    slot_le      [CAPACITY];

	logic                    out_valid_q;
	logic                    pop_ok_q;
	logic                    push_dropped_q;
	logic [TIME_BITS-1:0]    popped_time_q;
	logic [PAYLOAD_BITS-1:0] popped_payload_q;
	logic                    head_valid;
	logic [TIME_BITS-1:0]    head_time;
	logic [PAYLOAD_BITS-1:0] head_payload;

	// Take input when the result register is free or drains this cycle
	assign s_tready   = !out_valid_q || m_tready;
	assign in_xfer    = s_tvalid && s_tready;
	assign cmd        = cmd_t'(s_tuser);
	assign in_time    = s_tdata[TIME_BITS-1:0];
	assign in_payload = s_tdata[TIME_BITS +: PAYLOAD_BITS];
	assign full       = (count_q == CNT_BITS'(CAPACITY));
	assign empty      = (count_q == '0);

	// Decode the command into cell controls
	always_comb begin
		ctrl     = '0;
		clear_en = 1'b0;
		unique case (cmd)
			CMD_PUSH:  ctrl.push_en = in_xfer && !full;
			CMD_POP:   ctrl.pop_en  = in_xfer && !empty;
			CMD_CLEAR: clear_en     = in_xfer;
			default:   ;
		endcase
	end

	// Chain of cells, slot 0 is the head
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    left_le_w;
		logic [TIME_BITS-1:0]    left_time_w;
		logic [PAYLOAD_BITS-1:0] left_payload_w;
		logic [TIME_BITS-1:0]    right_time_w;
		logic [PAYLOAD_BITS-1:0] right_payload_w;

		if (i == 0) begin : g_first
			assign left_le_w      = 1'b1;
			assign left_time_w    = in_time;
			assign left_payload_w = in_payload;
		end else begin : g_mid
			assign left_le_w      = slot_le[i-1];
			assign left_time_w    = slot_time[i-1];
			assign left_payload_w = slot_payload[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_time_w    = slot_time[i];
			assign right_payload_w = slot_payload[i];
		end else begin : g_inner
			assign right_time_w    = slot_time[i+1];
			assign right_payload_w = slot_payload[i+1];
		end

		toeq_cell #(
			.TIME_BITS    (TIME_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.occupied      (CNT_BITS'(i) < count_q),
			.new_time      (in_time),
			.new_payload   (in_payload),
			.left_le       (left_le_w),
			.left_time     (left_time_w),
			.left_payload  (left_payload_w),
			.right_time    (right_time_w),
			.right_payload (right_payload_w),
			.le            (slot_le[i]),
			.slot_time     (slot_time[i]),
			.slot_payload  (slot_payload[i])
		);
	end

	// Advance the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear_en) begin
			count_q <= '0;
		end else if (ctrl.push_en) begin
			count_q <= count_q + 1'b1;
		end else if (ctrl.pop_en) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Hold the result valid until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the popped event and the drop flag
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pop_ok_q         <= ctrl.pop_en;
			push_dropped_q   <= (cmd == CMD_PUSH) && full;
			popped_time_q    <= ctrl.pop_en ? slot_time[0] : '0;
			popped_payload_q <= ctrl.pop_en ? slot_payload[0] : '0;
		end
	end

	// Head is read from slot 0; it holds while the result waits
	assign head_valid   = !empty;
	assign head_time    = head_valid ? slot_time[0] : '0;
	assign head_payload = head_valid ? slot_payload[0] : '0;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {head_valid, push_dropped_q, pop_ok_q};
	assign m_tdata  = OUT_W'({count_q, head_payload, head_time,
	                          popped_payload_q, popped_time_q});

	`TOEQ_ASSERT_NEXT(a_full_push_drops, in_xfer && (cmd == CMD_PUSH) && full,
		push_dropped_q && (count_q == CNT_BITS'(CAPACITY)), "push to full queue not dropped")
	`TOEQ_ASSERT_NEXT(a_pop_reports, in_xfer && (cmd == CMD_POP) && !empty,
		pop_ok_q && (count_q == $past(count_q) - 1'b1), "pop from non-empty queue lost")
	`TOEQ_ASSERT_NEXT(a_clear_empties, in_xfer && (cmd == CMD_CLEAR),
		(count_q == '0) && !head_valid, "clear left events in queue")
	`TOEQ_ASSERT_NEXT(a_count_idle, !in_xfer, $stable(count_q), "count changed without transfer")
	`TOEQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_BITS'(CAPACITY), "count above capacity")

endmodule

`default_nettype wire
